### hdl/bmrot_pkg.sv
// ----------------------------------------------------------------------------
// bmrot_pkg
// Shared widths, limits and codes for the 1-bpp bitmap rotate/scatter unit.
// ----------------------------------------------------------------------------
package bmrot_pkg;

   // geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 10;
   localparam int DIM_W    = 11;
   localparam int STRIDE_W = 8;
   localparam int INDEX_W  = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // pixel coordinate width (byte column plus bit position)
   localparam int COORD_W = COL_W + 3;

   // register reset values
   localparam logic [DIM_W-1:0]    WIDTH_RST  = DIM_W'(1024);
   localparam logic [DIM_W-1:0]    HEIGHT_RST = DIM_W'(1024);
   localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(128);

   // leftmost pixel of a plane byte
   localparam logic [BYTE_W-1:0] LEFT_PIXEL_MASK = 8'h80;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CANVAS_WIDTH  = 2'd0,
      CSR_CANVAS_HEIGHT = 2'd1,
      CSR_PLANE_STRIDE  = 2'd2,
      CSR_ROTATION      = 2'd3
   } csr_index_type;

   // quarter-turn codes
   typedef enum logic [1:0] {
      ROT_NONE    = 2'd0,
      ROT_QUARTER = 2'd1,
      ROT_HALF    = 2'd2,
      ROT_THREE_Q = 2'd3
   } rot_type;

endpackage

### hdl/bmrot_channels.sv
// ----------------------------------------------------------------------------
// bmrot channels
// Valid/ready channel interfaces for canvas bytes, plane results and
// register writes.
// ----------------------------------------------------------------------------
interface bmrot_req_if
   import bmrot_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   canvas_byte;
   logic [COL_W-1:0]    byte_column;
   logic [ROW_W-1:0]    canvas_row;

   modport source (output valid, canvas_byte, byte_column, canvas_row, input ready);
   modport sink   (input valid, canvas_byte, byte_column, canvas_row, output ready);
endinterface

interface bmrot_rsp_if
   import bmrot_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [INDEX_W-1:0]  plane_byte_index;
   logic [BYTE_W-1:0]   bit_mask;
   logic                last_of_byte;

   modport source (output valid, plane_byte_index, bit_mask, last_of_byte, input ready);
   modport sink   (input valid, plane_byte_index, bit_mask, last_of_byte, output ready);
endinterface

interface bmrot_csr_if
   import bmrot_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

### hdl/bitmap_rotate_scatter_1bpp_unit.sv
// ----------------------------------------------------------------------------
// bitmap_rotate_scatter_1bpp_unit
// Rotates the set pixels of 1-bpp canvas bytes and scatters them as plane
// byte offsets with one-hot masks.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  - one canvas byte with its byte column and row per item.
//   rsp_ch  - one item per set, in-range pixel, leftmost pixel first:
//             plane byte offset, one-hot mask, and last_of_byte on the final
//             item of that byte. A byte with no set in-range pixel gives none.
//   csr_ch  - register writes (width, height, stride, rotation); always
//             ready. Write only while the unit is idle.
// Pipeline: a byte's pixels pass through the pixel stage, then the output register.
// Throughput: one result item per cycle while rsp_ch.ready stays high; a byte with
//   set in-range pixels holds the input until they have all drained.
//   A new byte is taken in the same cycle its predecessor's last pixel moves
//   to the output register.
// Reset: registers return to 1024 x 1024, stride 128, no rotation; the
//   pixel stage and output register are emptied.
// Stall: while rsp_ch.ready is low the output register holds its item, the
//   pixel stage holds, and req_ch.ready drops once the stage is occupied.
// ----------------------------------------------------------------------------
module bitmap_rotate_scatter_1bpp_unit
   import bmrot_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bmrot_req_if.sink   req_ch,
   bmrot_rsp_if.source rsp_ch,
   bmrot_csr_if.sink   csr_ch
);

   // configuration registers
   logic [DIM_W-1:0]    width_ff;
   logic [DIM_W-1:0]    height_ff;
   logic [STRIDE_W-1:0] stride_ff;
   rot_type             rot_ff;

   // pixel stage: pending pixels in left-to-right order
   logic [7:0]          pend_ff, pend_in;
   logic [COL_W-1:0]    col_ff;
   logic [ROW_W-1:0]    row_ff;

   // output register
   logic                out_valid_ff;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic [BYTE_W-1:0]   mask_ff, mask_in;
   logic                last_ff, last_in;

   logic [DIM_W-1:0]    eff_w;
   logic [DIM_W-1:0]    eff_h;
   logic [7:0]          accept_mask;
   logic                req_fire;
   logic                out_free;
   logic                out_load;
   logic [2:0]          sel;
   logic [7:0]          pend_rest;
   logic [COORD_W-1:0]  x;
   logic [DIM_W-1:0]    px_wide, py_wide;
   logic [COORD_W-1:0]  px, py;
   logic [COORD_W+STRIDE_W-1:0] row_off;

   // register write port
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         stride_ff <= STRIDE_RST;
         rot_ff    <= ROT_NONE;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_CANVAS_WIDTH:  width_ff  <= csr_ch.wdata[DIM_W-1:0];
            CSR_CANVAS_HEIGHT: height_ff <= csr_ch.wdata[DIM_W-1:0];
            CSR_PLANE_STRIDE:  stride_ff <= csr_ch.wdata[STRIDE_W-1:0];
            CSR_ROTATION:      rot_ff    <= rot_type'(csr_ch.wdata[1:0]);
            default: ;
         endcase
      end
   end

   // effective geometry, clipped to the supported maximum
   assign eff_w = (32'(width_ff) < MAX_WIDTH)   ? width_ff  : DIM_W'(MAX_WIDTH);
   assign eff_h = (32'(height_ff) < MAX_HEIGHT) ? height_ff : DIM_W'(MAX_HEIGHT);

   // in-range set pixels of the incoming byte
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         accept_mask[b] = req_ch.canvas_byte[7-b]
                          && (DIM_W'({req_ch.byte_column, 3'(b)}) < eff_w)
                          && (DIM_W'(req_ch.canvas_row) < eff_h);
      end
   end

   // pick the leftmost pending pixel
   always_comb begin
      sel = 3'd0;
      for (int b = 7; b >= 0; b--) begin
         if (pend_ff[b]) begin
            sel = 3'(b);
         end
      end
      pend_rest = pend_ff & ~(8'b1 << sel);
   end

   // handshake control
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign out_load     = (pend_ff != 8'd0) && out_free;
   assign req_ch.ready = (pend_ff == 8'd0) || (out_load && (pend_rest == 8'd0));
   assign req_fire     = req_ch.valid && req_ch.ready;

   // rotation of the selected pixel
   assign x = {col_ff, sel};
   always_comb begin
      case (rot_ff)
         ROT_NONE: begin
            px_wide = DIM_W'(x);
            py_wide = DIM_W'(row_ff);
         end
         ROT_QUARTER: begin
            px_wide = eff_h - DIM_W'(1) - DIM_W'(row_ff);
            py_wide = DIM_W'(x);
         end
         ROT_HALF: begin
            px_wide = eff_w - DIM_W'(1) - DIM_W'(x);
            py_wide = eff_h - DIM_W'(1) - DIM_W'(row_ff);
         end
         ROT_THREE_Q: begin
            px_wide = DIM_W'(row_ff);
            py_wide = eff_w - DIM_W'(1) - DIM_W'(x);
         end
         default: begin
            px_wide = DIM_W'(x);
            py_wide = DIM_W'(row_ff);
         end
      endcase
      px = px_wide[COORD_W-1:0];
      py = py_wide[COORD_W-1:0];
   end

   // plane offset and mask
   assign row_off  = (COORD_W+STRIDE_W)'(py) * (COORD_W+STRIDE_W)'(stride_ff);
   assign index_in = INDEX_W'(row_off + (COORD_W+STRIDE_W)'(px[COORD_W-1:3]));
   assign mask_in  = LEFT_PIXEL_MASK >> px[2:0];
   assign last_in  = (pend_rest == 8'd0);

   // pixel stage update
   always_comb begin
      pend_in = pend_ff;
      if (out_load) begin
         pend_in = pend_rest;
      end
      if (req_fire) begin
         pend_in = accept_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 8'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         col_ff <= req_ch.byte_column;
         row_ff <= req_ch.canvas_row;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= out_load;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         index_ff <= index_in;
         mask_ff  <= mask_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.plane_byte_index = index_ff;
   assign rsp_ch.bit_mask         = mask_ff;
   assign rsp_ch.last_of_byte     = last_ff;

   // a new byte only enters an empty stage or one draining its last pixel
   assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (pend_ff == 8'd0)
                   || (out_load && ($countones(pend_ff) == 1)))
      else $error("byte accepted over pending pixels");

   // a shown result carries exactly one pixel
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot(mask_ff))
      else $error("result mask not one-hot");

   // after the last pixel leaves, the stage is empty or holds a new byte
   assert property (@(posedge clock) disable iff (reset)
      (out_load && last_in) |=> (pend_ff == 8'd0) || $past(req_fire))
      else $error("pixels left behind after last result");

   // a stalled output freezes the pixel stage unless a new byte is taken
   assert property (@(posedge clock) disable iff (reset)
      (!out_free && !req_fire) |=> $stable(pend_ff))
      else $error("pixel stage moved during stall");

endmodule
